/* src/skrsc_pkg.sv */
// ----------------------------------------------------------------------------
// skrsc_pkg
// Shared types and constants for the sorted key run set combiner.
// ----------------------------------------------------------------------------
package skrsc_pkg;

    // Field widths fixed by the stream format
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 32;
    localparam int TIMES_W = 8;
    localparam int MODE_W  = 4;
    localparam int SRC_W   = 8;

    // Default number of meaningful key bits
    localparam int KEY_BITS_DEF = 64;

    // Result queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Combine modes
    localparam logic [MODE_W-1:0] MODE_MERGE    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MIN      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MINEXIST = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MAX      = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ADD      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_AND      = 4'd5;
    localparam logic [MODE_W-1:0] MODE_NAND     = 4'd6;
    localparam logic [MODE_W-1:0] MODE_OR       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_XOR      = 4'd8;

    // Register indexes on the configuration port
    localparam logic REG_OP_MODE      = 1'b0;
    localparam logic REG_SOURCE_COUNT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0] OP_MODE_RST      = MODE_MERGE;
    localparam logic [SRC_W-1:0]  SOURCE_COUNT_RST = 8'd2;

    // One finished group on its way out
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic               last;
    } res_t;

    // Results written into the queue by one accepted item, oldest first
    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

endpackage

/* src/skrsc_front.sv */
// ----------------------------------------------------------------------------
// skrsc_front
// Group tracker: compares each item's key with the open group, combines the
// count and decides which finished groups are emitted.
// ----------------------------------------------------------------------------
module skrsc_front #(
    parameter int KEY_BITS = skrsc_pkg::KEY_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic [skrsc_pkg::KEY_W-1:0]  mer_key,
    input  logic [skrsc_pkg::COUNT_W-1:0] mer_count,
    input  logic                         end_of_stream,
    input  logic [skrsc_pkg::MODE_W-1:0] op_mode,
    input  logic [skrsc_pkg::SRC_W-1:0]  source_count,
    output skrsc_pkg::push_t             push
);
    import skrsc_pkg::*;

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic [TIMES_W-1:0]  times_reg, times_next;
    logic                open_reg, open_next;

    logic [KEY_BITS-1:0] key_in;
    logic                same;
    logic                set_mode;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  upd_total;
    logic [TIMES_W-1:0]  times_inc;
    logic                old_emit;
    logic                eos_emit;

    // Emit rule for a finished group
    function automatic logic emit_ok(input logic [MODE_W-1:0] m,
                                     input logic [TIMES_W-1:0] t,
                                     input logic [SRC_W-1:0]   s);
        logic ok;
        unique case (m)
            MODE_MIN, MODE_AND: ok = (t == s);
            MODE_NAND:          ok = (t != s);
            MODE_XOR:           ok = t[0];
            MODE_MERGE, MODE_MINEXIST, MODE_MAX, MODE_ADD, MODE_OR: ok = 1'b1;
            default:            ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Classify the item against the open group
    assign key_in   = mer_key[KEY_BITS-1:0];
    assign same     = open_reg && (key_in == key_reg);
    assign set_mode = (op_mode == MODE_AND) || (op_mode == MODE_NAND) ||
                      (op_mode == MODE_OR)  || (op_mode == MODE_XOR);
    assign sum      = {1'b0, total_reg} + {1'b0, mer_count};
    assign times_inc = (times_reg == {TIMES_W{1'b1}}) ? times_reg
                                                      : times_reg + 1'b1;

    // Combine the count by the mode in force
    always_comb begin
        priority if (op_mode == MODE_MIN || op_mode == MODE_MINEXIST) begin
            upd_total = (mer_count < total_reg) ? mer_count : total_reg;
        end else if (op_mode == MODE_MAX) begin
            upd_total = (mer_count > total_reg) ? mer_count : total_reg;
        end else if (set_mode) begin
            upd_total = COUNT_W'(1);
        end else begin
            upd_total = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
        end
    end

    // Next group state: extend the open group or open a fresh one
    always_comb begin
        key_next   = same ? key_reg : key_in;
        total_next = same ? upd_total : (set_mode ? COUNT_W'(1) : mer_count);
        times_next = same ? times_inc : TIMES_W'(1);
        open_next  = !end_of_stream;
    end

    // Decide which groups leave with this item
    assign old_emit = open_reg && !same && emit_ok(op_mode, times_reg, source_count);
    assign eos_emit = end_of_stream && emit_ok(op_mode, times_next, source_count);

    always_comb begin
        push.v0       = in_fire && old_emit;
        push.v1       = in_fire && eos_emit;
        push.r0.key   = KEY_W'(key_reg);
        push.r0.count = total_reg;
        push.r0.last  = !eos_emit;
        push.r1.key   = KEY_W'(key_next);
        push.r1.count = total_next;
        push.r1.last  = 1'b1;
    end

    // Hold group state between items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            total_reg <= '0;
            times_reg <= '0;
            open_reg  <= 1'b0;
        end else if (in_fire) begin
            key_reg   <= key_next;
            total_reg <= total_next;
            times_reg <= times_next;
            open_reg  <= open_next;
        end
    end

endmodule

/* src/skrsc_queue.sv */
// ----------------------------------------------------------------------------
// skrsc_queue
// Short result queue between front and back; takes up to two results per
// cycle and gives one.
// ----------------------------------------------------------------------------
module skrsc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  skrsc_pkg::push_t  push,
    output logic              room,
    output logic              not_empty,
    input  logic              pop,
    output skrsc_pkg::res_t   head
);
    import skrsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       n_push;
    res_t             first;
    logic [PTR_W-1:0] wr_ptr_p1;

    // Pack the pushed results so the oldest goes first
    assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
    assign first     = push.v0 ? push.r0 : push.r1;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    assign room      = (cnt_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    // Store results
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem[wr_ptr_reg] <= first;
        end
        if (n_push == 2'd2) begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* src/skrsc_back.sv */
// ----------------------------------------------------------------------------
// skrsc_back
// Output stage: moves results from the queue into the output register and
// holds them until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module skrsc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             not_empty,
    input  skrsc_pkg::res_t  head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output skrsc_pkg::res_t  out_res
);
    import skrsc_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;
    logic load;

    // Load when the register is free or being drained
    assign load       = not_empty && (!valid_reg || out_ready);
    assign pop        = load;
    assign valid_next = load || (valid_reg && !out_ready);

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= head;
        end
    end

endmodule

/* src/sorted_key_run_set_combiner_core.sv */
// ----------------------------------------------------------------------------
// sorted_key_run_set_combiner_core
// Combines runs of equal keys in a key-sorted count stream.
// ----------------------------------------------------------------------------
// Input stream s_axis: one (key, count) item per transfer, keys ascending;
// tlast marks the final item of the stream. Output stream m_axis: one
// finished group per transfer; tlast marks the last result caused by one
// input item (an item causes zero, one or two results).
// The APB port holds op_mode (address 0) and source_count (address 4);
// write them only while the block is idle.
// Throughput: one input item per cycle while the receiver keeps up, set by
// the combinational key compare and count update in the front stage. Each
// result is written into the queue at the input transfer and then moves
// into the output register. An item that causes two results leaves them
// in the queue, and they go out one per transfer.
// When the receiver stalls, results collect in a four-entry queue; s_axis
// tready drops once fewer than two entries are free, so nothing is lost.
// Reset clears the open group, the queue and the output register and
// restores op_mode to merge and source_count to 2.
// ----------------------------------------------------------------------------
module sorted_key_run_set_combiner_core #(
    parameter int KEY_BITS = skrsc_pkg::KEY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [63:0] mer_key, [95:64] mer_count
    input  logic        s_axis_tlast,   // end_of_stream
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [63:0] group_key, [95:64] group_count
    output logic        m_axis_tlast,   // last_of_item
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import skrsc_pkg::*;

    logic [MODE_W-1:0] op_mode_reg;
    logic [SRC_W-1:0]  source_count_reg;
    logic              cfg_wr;
    logic              in_fire;
    logic              room;
    logic              not_empty;
    logic              pop;
    push_t             push;
    res_t              head;
    res_t              out_res;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg      <= OP_MODE_RST;
            source_count_reg <= SOURCE_COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_OP_MODE) begin
                op_mode_reg <= pwdata[MODE_W-1:0];
            end else begin
                source_count_reg <= pwdata[SRC_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SOURCE_COUNT) ? 32'(source_count_reg)
                                                   : 32'(op_mode_reg);

    // Accept while the queue can take two results
    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    skrsc_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .mer_key       (s_axis_tdata[63:0]),
        .mer_count     (s_axis_tdata[95:64]),
        .end_of_stream (s_axis_tlast),
        .op_mode       (op_mode_reg),
        .source_count  (source_count_reg),
        .push          (push)
    );

    skrsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .not_empty (not_empty),
        .pop       (pop),
        .head      (head)
    );

    skrsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Drive the result stream
    assign m_axis_tdata = {out_res.count, out_res.key};
    assign m_axis_tlast = out_res.last;

endmodule

/* bench/sorted_key_run_set_combiner_core_tb.sv */
// ----------------------------------------------------------------------------
// sorted_key_run_set_combiner_core_tb
// Self-checking bench for the sorted key run set combiner.
// Streams mostly key-sorted (key, count) items through the block under every
// combine mode and a spread of source counts. A local predictor tracks the
// open key group and queues the finished groups that should come out. The
// monitor compares each result transfer with the oldest queued group. Both
// sides idle in random bursts, and the receiver holds off once for a long
// stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module sorted_key_run_set_combiner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skrsc_pkg::*;

    localparam int KEY_BITS = KEY_BITS_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TIMES_W-1:0] TIMES_MAX = '1;

    // Modes with no meaning: counts add up and every group is dropped
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;

    localparam logic [2:0] ADDR_OP_MODE      = {REG_OP_MODE, 2'b00};
    localparam logic [2:0] ADDR_SOURCE_COUNT = {REG_SOURCE_COUNT, 2'b00};

    localparam int LATENCY       = 2;
    localparam int SETTLE_CYCLES = LATENCY + 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 50000;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic               eos;
    } mer_item_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #2 aclk = ~aclk;

    // Block ports
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;    // [63:0] mer_key, [95:64] mer_count
    logic        s_tlast  = 1'b0;  // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;          // [63:0] group_key, [95:64] group_count
    logic        m_tlast;          // last_of_item
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    sorted_key_run_set_combiner_core #(
        .KEY_BITS (KEY_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Bench state
    mer_item_t item_q[$];      // items waiting to be offered
    res_t      group_q[$];     // finished groups still to come out
    int        fail_count  = 0;
    int        reg_errors  = 0;
    int        cycle_count = 0;
    logic      send_idle_on = 1'b1;
    logic      recv_idle_on = 1'b1;
    logic      hold_request = 1'b0;
    logic      hold_done    = 1'b0;
    int        hold_left    = 0;

    // Local copy of the configuration and of the open group
    logic [MODE_W-1:0]  cfg_mode    = OP_MODE_RST;
    logic [SRC_W-1:0]   cfg_sources = SOURCE_COUNT_RST;
    logic [KEY_W-1:0]   run_key     = '0;
    logic [COUNT_W-1:0] run_total   = '0;
    logic [TIMES_W-1:0] run_times   = '0;
    logic               run_open    = 1'b0;

    // Emit rule applied when a group finishes
    function automatic logic group_kept();
        case (cfg_mode)
            MODE_MIN, MODE_AND: return run_times == cfg_sources;
            MODE_NAND:          return run_times != cfg_sources;
            MODE_XOR:           return run_times[0];
            MODE_MERGE, MODE_MINEXIST, MODE_MAX, MODE_ADD, MODE_OR: return 1'b1;
            default:            return 1'b0;
        endcase
    endfunction

    // Fold one accepted item into the open group and queue what it finishes
    task automatic combine_item(input mer_item_t it);
        logic [KEY_W-1:0] k;
        logic [COUNT_W:0] sum;
        res_t             done[$];
        res_t             r;
        k = it.key & KEY_MASK;
        if (run_open && k == run_key) begin
            case (cfg_mode)
                MODE_MIN, MODE_MINEXIST: begin
                    if (it.count < run_total) run_total = it.count;
                end
                MODE_MAX: begin
                    if (it.count > run_total) run_total = it.count;
                end
                MODE_AND, MODE_NAND, MODE_OR, MODE_XOR: begin
                    run_total = 1;
                end
                default: begin
                    sum = {1'b0, run_total} + {1'b0, it.count};
                    run_total = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                end
            endcase
            if (run_times != TIMES_MAX) run_times = run_times + 1'b1;
        end else begin
            if (run_open && group_kept()) begin
                r.key = run_key; r.count = run_total; r.last = 1'b0;
                done.push_back(r);
            end
            run_key   = k;
            run_total = (cfg_mode == MODE_AND || cfg_mode == MODE_NAND ||
                         cfg_mode == MODE_OR || cfg_mode == MODE_XOR) ? 1 : it.count;
            run_times = TIMES_W'(1);
            run_open  = 1'b1;
        end
        // End of stream closes the group just updated or opened
        if (it.eos) begin
            if (group_kept()) begin
                r.key = run_key; r.count = run_total; r.last = 1'b0;
                done.push_back(r);
            end
            run_open = 1'b0;
        end
        foreach (done[i]) begin
            r = done[i];
            r.last = (i == done.size() - 1);
            group_q.push_back(r);
        end
    endtask

    // Driver: offer queued items, predict on each input transfer
    mer_item_t live_item;
    int        send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) combine_item(live_item);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    live_item = item_q.pop_front();
                    s_tdata  <= {live_item.count, live_item.key};
                    s_tlast  <= live_item.eos;
                    s_tvalid <= 1'b1;
                    if (send_idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result transfer, stall in random bursts
    int stall_left = 0;

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (group_q.size() == 0) begin
                    $error("unexpected result: group_key %h group_count %h last_of_item %b",
                           m_tdata[63:0], m_tdata[95:64], m_tlast);
                    fail_count++;
                end else begin
                    want = group_q.pop_front();
                    if (m_tdata[63:0] !== want.key) begin
                        $error("group_key: expected %h, actual %h", want.key, m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[95:64] !== want.count) begin
                        $error("group_count: expected %h, actual %h",
                               want.count, m_tdata[95:64]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_item: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Configuration port access, setup then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_OP_MODE) cfg_mode = value[MODE_W-1:0];
        else cfg_sources = value[SRC_W-1:0];
    endtask

    task automatic read_reg(input logic [2:0] addr, output logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read both registers back and compare with the local copy
    task automatic check_regs();
        logic [31:0] rd;
        read_reg(ADDR_OP_MODE, rd);
        if (rd[MODE_W-1:0] !== cfg_mode) begin
            $error("op_mode: expected %h, actual %h", cfg_mode, rd[MODE_W-1:0]);
            reg_errors++;
        end
        read_reg(ADDR_SOURCE_COUNT, rd);
        if (rd[SRC_W-1:0] !== cfg_sources) begin
            $error("source_count: expected %h, actual %h", cfg_sources, rd[SRC_W-1:0]);
            reg_errors++;
        end
    endtask

    // Wait until every item is in and every group is out, then settle
    task automatic wait_idle();
        do @(negedge aclk); while (item_q.size() != 0 || s_tvalid || group_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Change the setting while idle; upper data bits are junk the block drops
    task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] srcs);
        wait_idle();
        write_reg(ADDR_OP_MODE, ($urandom << MODE_W) | mode);
        write_reg(ADDR_SOURCE_COUNT, ($urandom << SRC_W) | srcs);
        check_regs();
        @(negedge aclk);
    endtask

    task automatic push_item(input logic [KEY_W-1:0] key, input logic [COUNT_W-1:0] count,
                             input logic eos);
        mer_item_t it;
        it.key = key; it.count = count; it.eos = eos;
        item_q.push_back(it);
    endtask

    // Counts weighted towards zero, saturation and small values
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return COUNT_MAX - $urandom_range(0, 3);
            2:       return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // Queue mostly sorted streams of key groups sized around the source count
    task automatic queue_phase(input int budget);
        int               n;
        int               sz;
        int               groups_left;
        logic [KEY_W-1:0] key;
        n = 0;
        key = {$urandom, $urandom} >> $urandom_range(0, 63);
        groups_left = $urandom_range(1, 12);
        while (n < budget) begin
            case ($urandom_range(0, 5))
                0, 1:    sz = int'(cfg_sources);
                2:       sz = int'(cfg_sources) + 1;
                3:       sz = int'(cfg_sources) - 1;
                default: sz = $urandom_range(1, 4);
            endcase
            if (sz < 1 || sz > 12) sz = $urandom_range(1, 4);
            // Mostly ascending keys, now and then an unsorted jump
            if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
            else key = key + $urandom_range(1, 3);
            groups_left--;
            for (int i = 0; i < sz; i++) begin
                push_item(key, pick_count(),
                          (groups_left == 0 && i == sz - 1) || $urandom_range(0, 60) == 0);
                n++;
            end
            if (groups_left == 0) groups_left = $urandom_range(1, 12);
        end
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] srcs,
                             input int budget);
        apply_setting(mode, srcs);
        queue_phase(budget);
    endtask

    // Stimulus sequence
    initial begin
        int               spin;
        logic [KEY_W-1:0] sat_key;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_regs();

        // Merge, two sources: first item keyed zero opens a group,
        // saturating sum, key change with end of stream, fresh group after it
        push_item('0, 5, 1'b0);
        push_item('0, 7, 1'b0);
        push_item(64'd1, 32'hFFFF_FFF0, 1'b0);
        push_item(64'd1, 32'h20, 1'b0);
        push_item(64'd2, 3, 1'b1);
        push_item(64'd2, 1, 1'b0);
        push_item({KEY_W{1'b1}}, COUNT_MAX, 1'b1);

        // Min keeps only groups seen in every source
        apply_setting(MODE_MIN, 2);
        push_item(64'd5, 9, 1'b0);
        push_item(64'd5, 0, 1'b0);
        push_item(64'd6, COUNT_MAX, 1'b1);

        // Xor with an odd number of items emits count one
        apply_setting(MODE_XOR, 3);
        push_item(64'h8000_0000_0000_0000, 4, 1'b0);
        push_item(64'h8000_0000_0000_0000, 0, 1'b0);
        push_item(64'h8000_0000_0000_0000, COUNT_MAX, 1'b1);
        push_item(64'h8000_0000_0000_0001, 2, 1'b1);

        // Random phases across all modes and a spread of source counts
        run_phase(MODE_MERGE, 3, 20);
        run_phase(MODE_MIN, 2, 20);
        run_phase(MODE_MINEXIST, 4, 20);
        run_phase(MODE_MAX, 255, 20);
        run_phase(MODE_ADD, 2, 20);
        run_phase(MODE_AND, 3, 20);
        run_phase(MODE_NAND, 2, 20);
        run_phase(MODE_OR, 1, 20);
        run_phase(MODE_XOR, 0, 20);
        run_phase(MODE_W'(int'(MODE_SPARE_FIRST) + $urandom_range(0, 6)), 2, 20);

        // Receiver holds off while the sender keeps offering
        apply_setting(MODE_ADD, 2);
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        queue_phase(60);
        wait_idle();
        send_idle_on = 1'b1;

        run_phase(MODE_SPARE_LAST, 255, 20);

        // One group long enough to saturate the item count
        apply_setting(MODE_MIN, 255);
        sat_key = {$urandom, $urandom};
        for (int i = 0; i < 260; i++) push_item(sat_key, pick_count(), 1'b0);
        push_item(sat_key + 1'b1, 1, 1'b1);

        run_phase(MODE_XOR, SRC_W'($urandom_range(2, 254)), 20);

        // Final stretch with no idling on either side
        apply_setting(MODE_MERGE, SRC_W'($urandom_range(2, 254)));
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        queue_phase(30);
        run_phase(MODE_NAND, 255, 30);

        // Drain and settle
        spin = 0;
        while ((item_q.size() != 0 || s_tvalid || group_q.size() != 0) && spin < DRAIN_LIMIT)
        begin
            @(negedge aclk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (group_q.size() != 0) begin
            $error("%0d expected groups never arrived", group_q.size());
            reg_errors++;
        end
        if (fail_count == 0 && reg_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
